@@ design/skl_pkg.sv @@
// ----------------------------------------------------------------------------
// skl_pkg: shared types and constants for the sorted key list
// Request and response transfer formats, request codes, and the link and
// command formats that pass between the cells of the sorted chain.
// ----------------------------------------------------------------------------
package skl_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int KEY_W        = 8;
	localparam int REQ_W        = 2;
	localparam int COUNT_OUT_W  = 5;

	// request codes
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

	// request transfer
	typedef struct packed {
		logic [REQ_W-1:0]        req_type;
		logic signed [KEY_W-1:0] key;
	} req_t;

	// response transfer
	typedef struct packed {
		logic                   found;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic                   overflow;
	} rsp_t;

	// operation broadcast to every cell
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t                op;
		logic signed [KEY_W-1:0] key;
	} cell_cmd_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic                    valid;
		logic signed [KEY_W-1:0] key;
		logic                    open;   // empty or holds a key above the command key
	} cell_link_t;

	localparam cell_link_t LINK_EMPTY = '{valid: 1'b0, key: '0, open: 1'b1};
	localparam cell_link_t LINK_EDGE  = '{valid: 1'b0, key: '0, open: 1'b0};

	// control state of the top level
	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_DELETE = 2'b10
	} skl_state_t;

endpackage

@@ design/skl_cell.sv @@
// ----------------------------------------------------------------------------
// skl_cell: one slot of the sorted chain
// Holds one key and its valid bit. On insert it either keeps its key, takes
// the new key, or takes its left neighbor's key; on remove it either keeps
// its key or takes its right neighbor's key.
// ----------------------------------------------------------------------------
module skl_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  skl_pkg::cell_cmd_t     cmd,
	input  skl_pkg::cell_link_t    left,
	input  skl_pkg::cell_link_t    right,
	output skl_pkg::cell_link_t    state,
	output logic                   match
);

	logic                                  valid_q;
	logic signed [skl_pkg::KEY_W-1:0]      key_q;
	logic                                  gt;
	logic                                  ge;

	// local compares against the broadcast key
	assign gt    = $signed(key_q) > $signed(cmd.key);
	assign ge    = $signed(key_q) >= $signed(cmd.key);
	assign match = valid_q && (key_q == cmd.key);

	assign state.valid = valid_q;
	assign state.key   = key_q;
	assign state.open  = !valid_q || gt;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				skl_pkg::OP_INSERT: begin
					if (left.open) begin
						valid_q <= left.valid;
					end else if (state.open) begin
						valid_q <= 1'b1;
					end
				end
				skl_pkg::OP_REMOVE: begin
					if (!valid_q || ge) begin
						valid_q <= right.valid;
					end
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	// key storage
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			skl_pkg::OP_INSERT: begin
				if (left.open) begin
					key_q <= left.key;
				end else if (state.open) begin
					key_q <= cmd.key;
				end
			end
			skl_pkg::OP_REMOVE: begin
				if (!valid_q || ge) begin
					key_q <= right.key;
				end
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

endmodule

@@ design/sorted_key_list.sv @@
// ----------------------------------------------------------------------------
// sorted_key_list: ascending list of signed keys in a chain of cells
// Insert keeps the list sorted (new key after equal keys), delete removes
// every copy of a key, find reports presence. One response per request.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+----------------------------------
//  request  | in  | req_valid/req_stall| req  (req_type, key)
//  response | out | rsp_valid/rsp_stall| rsp  (found, entry_count, overflow)
//
//  insert and find respond in the cycle after the request transfers; the response is registered.
//  delete shifts the stored copies of a key out of the chain, one copy per
//  cycle, then responds; a delete of an absent key skips the delete state.
//  reset empties the list at once through the cell valid bits.
//  request stalls while a delete runs or while a response waits to transfer.
//
module sorted_key_list #(
	parameter int CAPACITY = skl_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  skl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output skl_pkg::rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	skl_pkg::skl_state_t               state_q;
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     count_d;
	logic signed [skl_pkg::KEY_W-1:0]  del_key_q;
	logic                              rsp_valid_q;
	skl_pkg::rsp_t                     rsp_q;

	skl_pkg::cell_cmd_t                cmd;
	skl_pkg::cell_link_t               links [CAPACITY];
	logic [CAPACITY-1:0]               hit_vec;
	logic [CAPACITY-1:0]               valids;
	logic                              any_match;
	logic                              full;
	logic                              accept;
	logic                              rsp_take;
	logic                              emit;
	logic                              emit_found;
	logic                              emit_overflow;
	logic [CW+skl_pkg::COUNT_OUT_W-1:0] count_ext;

	// the cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skl_pkg::cell_link_t left_w;
		skl_pkg::cell_link_t right_w;

		if (i == 0) begin : g_first
			assign left_w = skl_pkg::LINK_EDGE;
		end else begin : g_mid_l
			assign left_w = links[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = skl_pkg::LINK_EMPTY;
		end else begin : g_mid_r
			assign right_w = links[i+1];
		end

		skl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (left_w),
			.right  (right_w),
			.state  (links[i]),
			.match  (hit_vec[i])
		);

		assign valids[i] = links[i].valid;
	end

	assign any_match = |hit_vec;
	assign full      = links[CAPACITY-1].valid;

	// handshakes
	assign rsp_take  = rsp_valid_q && !rsp_stall;
	assign req_stall = (state_q != skl_pkg::ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;

	// command to the cells, count update and response source
	always_comb begin
		cmd.op        = skl_pkg::OP_HOLD;
		cmd.key       = req.key;
		count_d       = count_q;
		emit          = 1'b0;
		emit_found    = 1'b0;
		emit_overflow = 1'b0;
		unique case (state_q)
			skl_pkg::ST_IDLE: begin
				if (accept) begin
					priority if (req.req_type == skl_pkg::REQ_INSERT) begin
						emit       = 1'b1;
						emit_found = any_match;
						if (full) begin
							emit_overflow = 1'b1;
						end else begin
							cmd.op  = skl_pkg::OP_INSERT;
							count_d = count_q + CW'(1);
						end
					end else if (req.req_type == skl_pkg::REQ_DELETE) begin
						if (any_match) begin
							cmd.op  = skl_pkg::OP_REMOVE;
							count_d = count_q - CW'(1);
						end else begin
							emit = 1'b1;
						end
					end else if (req.req_type == skl_pkg::REQ_FIND) begin
						emit       = 1'b1;
						emit_found = any_match;
					end else begin
						emit = 1'b1;
					end
				end
			end
			skl_pkg::ST_DELETE: begin
				cmd.key = del_key_q;
				if (any_match) begin
					cmd.op  = skl_pkg::OP_REMOVE;
					count_d = count_q - CW'(1);
				end else begin
					emit       = 1'b1;
					emit_found = 1'b1;
				end
			end
			default: begin
				cmd.op = skl_pkg::OP_HOLD;
			end
		endcase
	end

	// control state and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skl_pkg::ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			unique case (state_q)
				skl_pkg::ST_IDLE: begin
					if (accept && req.req_type == skl_pkg::REQ_DELETE && any_match) begin
						state_q <= skl_pkg::ST_DELETE;
					end
				end
				skl_pkg::ST_DELETE: begin
					if (!any_match) begin
						state_q <= skl_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= skl_pkg::ST_IDLE;
				end
			endcase
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_take) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// key under delete
	always_ff @(posedge clk) begin
		if (accept) begin
			del_key_q <= req.key;
		end
	end

	// response register
	assign count_ext = {{skl_pkg::COUNT_OUT_W{1'b0}}, count_d};

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.found       <= emit_found;
			rsp_q.entry_count <= count_ext[skl_pkg::COUNT_OUT_W-1:0];
			rsp_q.overflow    <= emit_overflow;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// occupied cells form the count
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valids) == int'(count_q))
		else $error("cell valid bits disagree with the entry count");

	// no response is pending while a delete runs
	a_delete_output_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == skl_pkg::ST_DELETE) |-> !rsp_valid_q)
		else $error("response pending during a delete");

	// an overflow response means the list was full
	a_overflow_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.overflow) |-> (count_q == CW'(CAPACITY)))
		else $error("overflow reported on a list that is not full");

	// delete progress always removes one copy per cycle
	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == skl_pkg::ST_DELETE && any_match) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("delete cycle did not remove a copy");
`endif

endmodule

@@ tb/sv/sorted_list_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_checker: response predictor and scoreboard for sorted_key_list
// Follows request and response transfers, keeps its own copy of the sorted
// list, and compares every response field in order with the predicted one.
// ----------------------------------------------------------------------------
module sorted_list_checker
	import skl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  rsp_t        rsp,
	output int unsigned failures,
	output int unsigned outstanding
);

	// shadow copy of the list, ascending in signed order
	logic signed [KEY_W-1:0] list_keys[$];
	// predicted responses not yet seen, oldest first
	rsp_t                    due_rsp[$];

	initial begin
		failures    = 0;
		outstanding = 0;
	end

	// apply one request to the shadow list and return its response
	function automatic rsp_t apply_request(req_t r);
		rsp_t res;
		int   pos;
		res = '0;
		foreach (list_keys[i])
			if (list_keys[i] == r.key) res.found = 1'b1;
		case (r.req_type)
			REQ_INSERT: begin
				if (list_keys.size() >= CAPACITY) begin
					res.overflow = 1'b1;
				end else begin
					// new key goes after any equal keys
					pos = 0;
					while (pos < list_keys.size() && list_keys[pos] <= r.key) pos++;
					list_keys.insert(pos, r.key);
				end
			end
			REQ_DELETE: begin
				for (int i = list_keys.size() - 1; i >= 0; i--)
					if (list_keys[i] == r.key) list_keys.delete(i);
			end
			REQ_FIND: ;
			// unused code reports nothing found
			default: res.found = 1'b0;
		endcase
		// only the low bits of the count travel
		res.entry_count = COUNT_OUT_W'(list_keys.size());
		return res;
	endfunction

	task automatic report(string what, logic [COUNT_OUT_W-1:0] want,
			logic [COUNT_OUT_W-1:0] got);
		failures++;
		if (failures <= 50)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endtask

	// compare one response transfer with the oldest prediction
	task automatic check_rsp(rsp_t got);
		rsp_t want;
		if (due_rsp.size() == 0) begin
			failures++;
			if (failures <= 50)
				$display("%0t: response with none expected, expected nothing, got %p",
					$time, got);
			return;
		end
		want = due_rsp.pop_front();
		if (got.found !== want.found) report("found", want.found, got.found);
		if (got.entry_count !== want.entry_count)
			report("entry_count", want.entry_count, got.entry_count);
		if (got.overflow !== want.overflow) report("overflow", want.overflow, got.overflow);
	endtask

	// responses are checked before the request of the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_keys.delete();
			due_rsp.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) check_rsp(rsp);
			if (req_valid && !req_stall) due_rsp.push_back(apply_request(req));
			outstanding <= due_rsp.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for sorted_key_list
// Drives directed and random insert, delete and find requests with random
// gaps and response stalls; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import skl_pkg::*;

	localparam int CAP          = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1700;
	localparam int ROUNDS       = 12;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 40;
	localparam int CYCLE_LIMIT  = 400000;

	// request code the block must ignore
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req       = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b1;
	rsp_t        rsp;
	int unsigned failures;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	int unsigned sent        = 0;
	int unsigned taken       = 0;

	logic signed [KEY_W-1:0] key_pool[6];

	sorted_key_list #(.CAPACITY(CAP)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	sorted_list_checker #(.CAPACITY(CAP)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.failures   (failures),
		.outstanding(outstanding)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// offer one request after a random gap and hold it until the transfer
	task automatic send(logic [REQ_W-1:0] kind, logic signed [KEY_W-1:0] k);
		int unsigned gap;
		gap = (sent % 400 >= 200 && sent % 400 < 260) ? 0 : $urandom_range(11);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{req_type: kind, key: k};
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent++;
	endtask

	// stop offering until every predicted response has arrived
	task automatic wait_all_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// mostly keys from a small pool so duplicates pile up
	function automatic logic signed [KEY_W-1:0] pick_key();
		if ($urandom_range(3) == 0) return KEY_W'($urandom);
		return key_pool[$urandom_range(5)];
	endfunction

	function automatic logic [REQ_W-1:0] pick_kind(mix_t mix);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 4) return REQ_UNUSED;
		case (mix)
			MIX_FILL:  return roll < 70 ? REQ_INSERT : (roll < 82 ? REQ_DELETE : REQ_FIND);
			MIX_DRAIN: return roll < 30 ? REQ_INSERT : (roll < 75 ? REQ_DELETE : REQ_FIND);
			default:   return roll < 45 ? REQ_INSERT : (roll < 70 ? REQ_DELETE : REQ_FIND);
		endcase
	endfunction

	// response side: random stalls, two long hold-offs, stretches with none
	initial begin : response_sink
		int unsigned hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken == 300 || taken == 1000)
				hold = LONG_HOLD;
			else if (taken % 400 >= 100 && taken % 400 < 180)
				hold = 0;
			else
				hold = $urandom_range(11);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			taken++;
		end
	end

	// reset, directed requests, random rounds, verdict
	initial begin : stimulus
		mix_t mix;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, extremes, duplicates, absent keys, unused code
		send(REQ_FIND, 0);
		send(REQ_INSERT, 127);
		send(REQ_INSERT, -128);
		send(REQ_INSERT, 0);
		send(REQ_INSERT, 0);
		send(REQ_INSERT, -1);
		send(REQ_FIND, 0);
		send(REQ_FIND, 5);
		send(REQ_DELETE, 0);
		send(REQ_DELETE, 42);
		send(REQ_UNUSED, 85);
		// fill to capacity and one past it, then a long delete
		for (int i = 0; i < CAP - 2; i++) send(REQ_INSERT, 7);
		send(REQ_DELETE, 7);

		for (int r = 0; r < ROUNDS; r++) begin
			foreach (key_pool[i]) begin
				case ($urandom_range(5))
					0:       key_pool[i] = -128;
					1:       key_pool[i] = 127;
					2:       key_pool[i] = 0;
					3:       key_pool[i] = -1;
					default: key_pool[i] = KEY_W'($urandom);
				endcase
			end
			mix = mix_t'(r % 3);
			if (r == 4) wait_all_responses();
			for (int i = 0; i < RANDOM_ITEMS / ROUNDS; i++) send(pick_kind(mix), pick_key());
		end

		wait_all_responses();
		repeat (SETTLE) @(posedge clk);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
